FILE: src/cse_pkg.sv
package cse_pkg;

  // operation codes of an input beat
  typedef enum logic [1:0] {
    OP_SECOND = 2'd0,
    OP_FAST   = 2'd1,
    OP_START  = 2'd2
  } cse_op_t;

  // fast timer action codes
  typedef enum logic [1:0] {
    ACT_LEAVE   = 2'd0,
    ACT_DISABLE = 2'd1,
    ACT_START   = 2'd2,
    ACT_ADVANCE = 2'd3
  } cse_act_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_X_BAND_LOW        = 3'd0,
    REG_X_BAND_HIGH       = 3'd1,
    REG_Y_BAND_LOW        = 3'd2,
    REG_Y_BAND_HIGH       = 3'd3,
    REG_MID_EXCEED_LIMIT  = 3'd4,
    REG_HIGH_EXCEED_LIMIT = 3'd5,
    REG_RECOVERY_LIMIT    = 3'd6
  } cse_reg_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [1:0] SPEED_SLOW = 2'd1;
  localparam logic [1:0] SPEED_MID  = 2'd2;
  localparam logic [1:0] SPEED_HIGH = 2'd3;

  localparam logic [15:0] FAST_PERIOD_MID  = 16'd16384;
  localparam logic [15:0] FAST_PERIOD_HIGH = 16'd8192;

  typedef struct packed {
    logic [7:0]  x_band_low;
    logic [7:0]  x_band_high;
    logic [7:0]  y_band_low;
    logic [7:0]  y_band_high;
    logic [15:0] mid_exceed_limit;
    logic [15:0] high_exceed_limit;
    logic [15:0] recovery_limit;
  } cse_cfg_t;

  typedef struct packed {
    logic        count_step;
    logic        drop_to_zero;
    logic [1:0]  speed_level;
    logic [1:0]  fast_action;
    logic [15:0] fast_period;
  } cse_res_t;

endpackage

FILE: src/cse_cfg.sv
module cse_cfg
  import cse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cse_cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_band_low        <= 8'd0;
      cfg.x_band_high       <= 8'd255;
      cfg.y_band_low        <= 8'd0;
      cfg.y_band_high       <= 8'd255;
      cfg.mid_exceed_limit  <= 16'd5;
      cfg.high_exceed_limit <= 16'd5;
      cfg.recovery_limit    <= 16'd5;
    end else if (wr_en) begin
      case (wr_index)
        REG_X_BAND_LOW:        cfg.x_band_low        <= wr_data[7:0];
        REG_X_BAND_HIGH:       cfg.x_band_high       <= wr_data[7:0];
        REG_Y_BAND_LOW:        cfg.y_band_low        <= wr_data[7:0];
        REG_Y_BAND_HIGH:       cfg.y_band_high       <= wr_data[7:0];
        REG_MID_EXCEED_LIMIT:  cfg.mid_exceed_limit  <= wr_data;
        REG_HIGH_EXCEED_LIMIT: cfg.high_exceed_limit <= wr_data;
        REG_RECOVERY_LIMIT:    cfg.recovery_limit    <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/cse_core.sv
module cse_core
  import cse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [1:0] op,
  input  logic [7:0] ax,
  input  logic [7:0] ay,
  input  cse_cfg_t   cfg,
  output cse_res_t   res
);

  logic [1:0]  speed, speed_next;
  logic [15:0] mid_exceed_count, mid_exceed_count_next;
  logic [15:0] high_exceed_count, high_exceed_count_next;
  logic [15:0] recovery_count, recovery_count_next;
  logic        x_quiet, y_quiet;
  logic        step, drop;
  logic [1:0]  act;
  logic [15:0] period;

  assign x_quiet = (ax < cfg.x_band_low) || (ax > cfg.x_band_high);
  assign y_quiet = (ay < cfg.y_band_low) || (ay > cfg.y_band_high);

  always_comb begin
    speed_next             = speed;
    mid_exceed_count_next  = mid_exceed_count;
    high_exceed_count_next = high_exceed_count;
    recovery_count_next    = recovery_count;
    step   = 1'b0;
    drop   = 1'b0;
    act    = ACT_LEAVE;
    period = 16'd0;
    case (op)
      OP_SECOND: begin
        if (x_quiet && y_quiet) begin
          if (speed == SPEED_SLOW) begin
            act  = ACT_DISABLE;
            step = 1'b1;
          end else if (speed == SPEED_MID || speed == SPEED_HIGH) begin
            if (speed == SPEED_MID) mid_exceed_count_next = cfg.mid_exceed_limit;
            else                    high_exceed_count_next = cfg.high_exceed_limit;
            // recovery run-down
            if (recovery_count != 16'd0) begin
              recovery_count_next = recovery_count - 16'd1;
            end else begin
              speed_next          = SPEED_SLOW;
              recovery_count_next = cfg.recovery_limit;
              step                = 1'b1;
            end
          end
        end else begin
          recovery_count_next = cfg.recovery_limit;
          // checks fall through, each sees the speed set above it
          if (speed_next == SPEED_SLOW) begin
            speed_next = SPEED_MID;
            act        = ACT_START;
            period     = FAST_PERIOD_MID;
            step       = 1'b1;
          end
          if (speed_next == SPEED_MID) begin
            if (mid_exceed_count != 16'd0) begin
              mid_exceed_count_next = mid_exceed_count - 16'd1;
            end else begin
              mid_exceed_count_next = cfg.mid_exceed_limit;
              speed_next            = SPEED_HIGH;
            end
          end
          if (speed_next == SPEED_HIGH) begin
            if (high_exceed_count != 16'd0) begin
              high_exceed_count_next = high_exceed_count - 16'd1;
            end else begin
              drop = 1'b1;
            end
          end
        end
      end
      OP_FAST: begin
        if (speed == SPEED_MID) begin
          act    = ACT_ADVANCE;
          period = FAST_PERIOD_MID;
          step   = 1'b1;
        end else if (speed == SPEED_HIGH) begin
          act    = ACT_ADVANCE;
          period = FAST_PERIOD_HIGH;
          step   = 1'b1;
        end
      end
      OP_START: begin
        mid_exceed_count_next  = cfg.mid_exceed_limit;
        high_exceed_count_next = cfg.high_exceed_limit;
        recovery_count_next    = cfg.recovery_limit;
        speed_next             = SPEED_SLOW;
        act                    = ACT_DISABLE;
      end
      default: ;
    endcase
  end

  assign res.count_step   = step;
  assign res.drop_to_zero = drop;
  assign res.speed_level  = speed_next;
  assign res.fast_action  = act;
  assign res.fast_period  = period;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed             <= SPEED_SLOW;
      mid_exceed_count  <= 16'd0;
      high_exceed_count <= 16'd0;
      recovery_count    <= 16'd0;
    end else if (take) begin
      speed             <= speed_next;
      mid_exceed_count  <= mid_exceed_count_next;
      high_exceed_count <= high_exceed_count_next;
      recovery_count    <= recovery_count_next;
    end
  end

endmodule

FILE: src/countdown_speed_escalator_unit.sv
// Activity-driven countdown rate controller. Each input beat is a second tick
// carrying an x/y accelerometer sample, a fast tick, or a start. A second
// tick is quiet when both axes fall outside their inclusive bands; quiet
// seconds run the recovery counter down toward speed 1, active seconds climb
// speed 1 to 2 to 3 and, once speed 3 is used up, raise drop_to_zero. Fast
// ticks at speeds 2 and 3 add a count step and give the next fast period.
// Every input beat yields exactly one result beat. The block is a two-stage
// pipeline: an input register, then one pass of short update logic that
// writes both the controller state and the result register at the same
// edge. One beat per cycle is sustained while out_ready stays high; the
// limit is the state update loop. Configuration writes are always accepted
// (cfg_ready is tied high) and should only be issued while no beat is in
// flight.
module countdown_speed_escalator_unit
  import cse_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             operation,
  input  logic [7:0]             accel_x,
  input  logic [7:0]             accel_y,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   count_step,
  output logic                   drop_to_zero,
  output logic [1:0]             speed_level,
  output logic [1:0]             fast_action,
  output logic [15:0]            fast_period,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cse_cfg_t   cfg;
  cse_res_t   res;
  cse_res_t   out_res;

  // input stage
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [7:0] s1_ax;
  logic [7:0] s1_ay;

  logic       s2_take;
  logic       in_take;

  assign cfg_ready = 1'b1;

  // stage one hands its beat on when the result register is empty or draining
  assign s2_take  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s2_take;
  assign in_take  = in_valid && in_ready;

  cse_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op <= operation;
      s1_ax <= accel_x;
      s1_ay <= accel_y;
    end
  end

  // state update and result computation for the beat in stage one
  cse_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (s2_take),
    .op   (s1_op),
    .ax   (s1_ax),
    .ay   (s1_ay),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      out_res <= res;
    end
  end

  assign count_step   = out_res.count_step;
  assign drop_to_zero = out_res.drop_to_zero;
  assign speed_level  = out_res.speed_level;
  assign fast_action  = out_res.fast_action;
  assign fast_period  = out_res.fast_period;

`ifndef SYNTHESIS
  // speed never leaves the 1..3 range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speed_level != 2'd0)
    else $error("speed level out of range");

  // drop to zero only ever happens at the top speed
  assert property (@(posedge clk) disable iff (rst)
    out_valid && drop_to_zero |-> speed_level == SPEED_HIGH)
    else $error("drop to zero below top speed");

  // starting the fast timer moves off speed 1 with the mid period
  assert property (@(posedge clk) disable iff (rst)
    out_valid && fast_action == ACT_START |->
      fast_period == FAST_PERIOD_MID && speed_level != SPEED_SLOW)
    else $error("fast timer start inconsistent");

  // an empty result register never blocks the input
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");
`endif

endmodule
